[hw/rtl/lcdns_pkg.sv]
// Shared types, codes and the init table for the LCD nibble command sequencer.
package lcdns_pkg;

  // Command codes carried in the op field.
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_SET_POS = 2'd1;
  localparam logic [1:0] OP_PUT_CHAR = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Field widths of a transfer.
  localparam int HoldWidth = 15;
  localparam int NibbleWidth = 4;

  // Init table size and the width of the step counter that walks it.
  localparam int InitTableSize = 13;
  localparam int StepWidth = $clog2(InitTableSize);

  // Hold times in microseconds.
  localparam logic [HoldWidth-1:0] HOLD_POWER_UP = 15'd20000;
  localparam logic [HoldWidth-1:0] HOLD_LONG = 15'd10000;
  localparam logic [HoldWidth-1:0] HOLD_SHORT = 15'd100;

  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 2;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCountWidth = $clog2(QueueDepth + 1);

  // One classified command as it waits in the queue.
  typedef struct packed {
    logic is_init;
    logic reg_select;
    logic [7:0] data;
  } qent_t;

  // Nibble of each init step.
  function automatic logic [NibbleWidth-1:0] init_nibble(input logic [StepWidth-1:0] idx);
    logic [NibbleWidth-1:0] nib;
    case (idx)
      4'd0: nib = 4'h0;
      4'd1: nib = 4'h3;
      4'd2: nib = 4'h3;
      4'd3: nib = 4'h3;
      4'd4: nib = 4'h2;
      4'd5: nib = 4'h2;
      4'd6: nib = 4'hC;
      4'd7: nib = 4'h0;
      4'd8: nib = 4'hC;
      4'd9: nib = 4'h0;
      4'd10: nib = 4'h1;
      4'd11: nib = 4'h0;
      4'd12: nib = 4'h6;
      default: nib = 4'h0;
    endcase
    return nib;
  endfunction

  // Hold time of each init step.
  function automatic logic [HoldWidth-1:0] init_hold(input logic [StepWidth-1:0] idx);
    logic [HoldWidth-1:0] hold;
    case (idx)
      4'd0: hold = HOLD_POWER_UP;
      4'd1: hold = HOLD_LONG;
      4'd10: hold = HOLD_LONG;
      default: hold = HOLD_SHORT;
    endcase
    return hold;
  endfunction

endpackage

[hw/rtl/lcdns_if.sv]
// Valid/ready channel interfaces for commands and bus transfers.
interface lcdns_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic [5:0] column;
  logic line;
  logic [7:0] char_code;

  modport source(output valid, output op, output column, output line, output char_code,
                 input ready);
  modport sink(input valid, input op, input column, input line, input char_code,
               output ready);
endinterface

interface lcdns_xfer_if;
  logic valid;
  logic ready;
  logic reg_select;
  logic [3:0] nibble;
  logic [14:0] hold_us;
  logic last;

  modport source(output valid, output reg_select, output nibble, output hold_us,
                 output last, input ready);
  modport sink(input valid, input reg_select, input nibble, input hold_us, input last,
               output ready);
endinterface

[hw/rtl/lcdns_front.sv]
// Front end: accepts commands and classifies them into queue entries.
module lcdns_front (
  lcdns_cmd_if.sink cmd,
  input logic q_full,
  output logic push,
  output lcdns_pkg::qent_t push_data
);

  // Take a command whenever the queue has room.
  assign cmd.ready = !q_full;

  // The unused op code is accepted and dropped.
  assign push = cmd.valid && cmd.ready && (cmd.op != lcdns_pkg::OP_UNUSED);

  // Set-position forms 128 + column + 64 * line; the column never carries into bit 6.
  always_comb begin
    push_data = '0;
    case (cmd.op)
      lcdns_pkg::OP_INIT: begin
        push_data.is_init = 1'b1;
      end
      lcdns_pkg::OP_SET_POS: begin
        push_data.data = {1'b1, cmd.line, cmd.column};
      end
      lcdns_pkg::OP_PUT_CHAR: begin
        push_data.reg_select = 1'b1;
        push_data.data = cmd.char_code;
      end
      default: begin
        push_data = '0;
      end
    endcase
  end

endmodule

[hw/rtl/lcdns_queue.sv]
// Short queue of classified commands between the front and the back.
module lcdns_queue (
  input logic clk,
  input logic rst,
  input logic push,
  input lcdns_pkg::qent_t push_data,
  output logic full,
  output logic pop_valid,
  input logic pop,
  output lcdns_pkg::qent_t pop_data
);

  lcdns_pkg::qent_t mem [lcdns_pkg::QueueDepth];
  logic [lcdns_pkg::QueuePtrWidth-1:0] wr_ptr;
  logic [lcdns_pkg::QueuePtrWidth-1:0] rd_ptr;
  logic [lcdns_pkg::QueueCountWidth-1:0] count;

  assign full = (count == lcdns_pkg::QueueCountWidth'(lcdns_pkg::QueueDepth));
  assign pop_valid = (count != '0);
  assign pop_data = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lcdns_back.sv]
// Back end: plays out each queued command as nibble transfers into an output register.
module lcdns_back #(
  parameter int INIT_STEPS = 13
) (
  input logic clk,
  input logic rst,
  input logic q_valid,
  output logic pop,
  input lcdns_pkg::qent_t q_data,
  lcdns_xfer_if.source xfer
);

  localparam int NumSteps =
      (INIT_STEPS > lcdns_pkg::InitTableSize) ? lcdns_pkg::InitTableSize : INIT_STEPS;
  localparam logic [lcdns_pkg::StepWidth-1:0] LastInitStep =
      lcdns_pkg::StepWidth'(NumSteps - 1);

  lcdns_pkg::qent_t cur;
  logic busy;
  logic [lcdns_pkg::StepWidth-1:0] step;

  logic out_valid;
  logic out_rs;
  logic [lcdns_pkg::NibbleWidth-1:0] out_nibble;
  logic [lcdns_pkg::HoldWidth-1:0] out_hold;
  logic out_last;

  logic gen_rs;
  logic [lcdns_pkg::NibbleWidth-1:0] gen_nibble;
  logic [lcdns_pkg::HoldWidth-1:0] gen_hold;
  logic gen_last;
  logic advance;

  // Transfer for the current step of the active command.
  always_comb begin
    if (cur.is_init) begin
      gen_rs = 1'b0;
      gen_nibble = lcdns_pkg::init_nibble(step);
      gen_hold = lcdns_pkg::init_hold(step);
      gen_last = (step == LastInitStep);
    end else begin
      gen_rs = cur.reg_select;
      gen_nibble = step[0] ? cur.data[3:0] : cur.data[7:4];
      gen_hold = lcdns_pkg::HOLD_SHORT;
      gen_last = step[0];
    end
  end

  // A transfer moves into the output register when that register is free or draining.
  assign advance = busy && (!out_valid || xfer.ready);
  // The next command loads when idle or as the last transfer of this one leaves.
  assign pop = q_valid && (!busy || (advance && gen_last));

  // Command and step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      step <= '0;
    end else if (advance) begin
      if (gen_last) begin
        busy <= 1'b0;
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (xfer.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_rs <= gen_rs;
      out_nibble <= gen_nibble;
      out_hold <= gen_hold;
      out_last <= gen_last;
    end
  end

  assign xfer.valid = out_valid;
  assign xfer.reg_select = out_rs;
  assign xfer.nibble = out_nibble;
  assign xfer.hold_us = out_hold;
  assign xfer.last = out_last;

endmodule

[hw/rtl/lcd_nibble_command_sequencer.sv]
// Top level of the LCD nibble command sequencer: front, queue and back joined.
//
//   channel | direction | handshake     | payload
//   cmd     | in        | valid / ready | op, column, line, char_code
//   xfer    | out       | valid / ready | reg_select, nibble, hold_us, last
//
// A command emits one transfer per cycle while xfer is ready: init gives INIT_STEPS
// transfers (capped at 13), set-position and put-char give two, an unused op none.
// The back end's step counter paces the transfers, with no gap between commands when the
// next command is already queued. From an idle back end, the first transfer of a command
// passes through the queue, the command and step registers and the output register first.
// The two-entry queue lets cmd keep accepting while the back end works.
// Reset is synchronous and clears the queue, the step control and the output valid.
// A stall on xfer holds the output register; cmd stalls only when the queue is full.
module lcd_nibble_command_sequencer #(
  parameter int INIT_STEPS = 13
) (
  input logic clk,
  input logic rst,
  lcdns_cmd_if.sink cmd,
  lcdns_xfer_if.source xfer
);

  logic q_full;
  logic push;
  lcdns_pkg::qent_t push_data;
  logic q_valid;
  logic pop;
  lcdns_pkg::qent_t q_data;

  lcdns_front u_front (
    .cmd(cmd),
    .q_full(q_full),
    .push(push),
    .push_data(push_data)
  );

  lcdns_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .full(q_full),
    .pop_valid(q_valid),
    .pop(pop),
    .pop_data(q_data)
  );

  lcdns_back #(
    .INIT_STEPS(INIT_STEPS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .pop(pop),
    .q_data(q_data),
    .xfer(xfer)
  );

endmodule

[hw/rtl/lcdns_checker.sv]
// Port-level checks on the sequencer's transfer channel, bound to the top level.
module lcdns_checker (
  input logic clk,
  input logic rst,
  input logic xfer_valid,
  input logic xfer_ready,
  input logic xfer_reg_select,
  input logic [3:0] xfer_nibble,
  input logic [14:0] xfer_hold_us,
  input logic xfer_last
);

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !xfer_valid)
    else $error("transfer offered right after reset");

  // A stalled transfer holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    xfer_valid && !xfer_ready |=> xfer_valid && $stable(xfer_reg_select) &&
      $stable(xfer_nibble) && $stable(xfer_hold_us) && $stable(xfer_last))
    else $error("stalled transfer changed");

  // Data transfers always use the short hold.
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    xfer_valid && xfer_reg_select |-> xfer_hold_us == 15'd100)
    else $error("data transfer with a long hold");

  // The low nibble of a character follows its high nibble in the next cycle.
  a_char_pair: assert property (@(posedge clk) disable iff (rst)
    xfer_valid && xfer_ready && xfer_reg_select && !xfer_last |=>
      xfer_valid && xfer_reg_select && xfer_last)
    else $error("character low nibble missing after high nibble");

endmodule

bind lcd_nibble_command_sequencer lcdns_checker u_lcdns_checker (
  .clk(clk),
  .rst(rst),
  .xfer_valid(xfer.valid),
  .xfer_ready(xfer.ready),
  .xfer_reg_select(xfer.reg_select),
  .xfer_nibble(xfer.nibble),
  .xfer_hold_us(xfer.hold_us),
  .xfer_last(xfer.last)
);
